[rtl/core/ptst_pkg.sv]
// shared types and constants for the periodic tick subscription table
// used by ptst_cell, ptst_ctrl and periodic_tick_subscription_table
package ptst_pkg;

	localparam int TIME_W      = 32;
	localparam int SLOT_W      = 5;
	localparam int SLOT_ADDR_N = 32;
	localparam int ID_W        = 6;
	localparam int MAX_RESULTS = 32;
	localparam int FCNT_W      = 6;
	localparam logic [ID_W-1:0] NO_SLOT = 6'd32;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_SUB     = 2'd1,
		KIND_ENABLE  = 2'd2,
		KIND_DISABLE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EV_FIRED      = 3'd0,
		EV_NOFIRE     = 3'd1,
		EV_SUBSCRIBED = 3'd2,
		EV_FULL       = 3'd3,
		EV_DONE       = 3'd4
	} event_t;

	// broadcast from the sequencer to every cell of the chain
	typedef struct packed {
		logic              start;
		logic              adv;
		logic              flush;
		logic              take;
		logic              sub_mode;
		logic              wr_en;
		logic              wr_val;
		logic [SLOT_W-1:0] wr_slot;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] interval;
	} cell_ctrl_t;

endpackage

[rtl/core/periodic_tick_subscription_table.sv]
// an enable/disable item passes the emit state into the output register; subscribe and tick
// items first walk the scan token along the cell chain, one slot per cycle while no fire
// report waits on a stalled output; a new input item is taken only in idle, once the last
// one's final result sits in the output register, which lets the next item in while it waits
// reset (arst_n low, asynchronous): time counter zero, all slots free and disabled;
// period and last-fire storage is not cleared, a slot's copy is written when it is claimed
module periodic_tick_subscription_table #(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // kind
	input  logic [39:0] s_tdata,   // slot[4:0], interval[36:5], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // event_res
	output logic [7:0]  m_tdata,   // slot_id[5:0], zero fill
	output logic        m_tlast    // last item caused by this input
);

	// broadcast control from the sequencer
	ptst_pkg::cell_ctrl_t ctrl;

	// scan token ripple: entry 0 is the start pulse, entry i+1 is cell i's token
	logic [SLOTS:0]   tok;
	logic [SLOTS-1:0] hit_vec;
	logic             hit_any;

	assign tok[0]  = ctrl.start;
	// at most one cell holds the token, so at most one cell can report a hit
	assign hit_any = |hit_vec;

	ptst_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.hit_any  (hit_any),
		.ctrl     (ctrl)
	);

	// one cell per slot, token handed from cell i to cell i+1 on each scan step
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ptst_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.hit     (hit_vec[i])
		);
	end

	// the token walks alone through the chain
	a_token_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok[SLOTS:1]))
		else $error("more than one scan token in the chain");

	// a scan only starts with an empty chain
	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> (tok[SLOTS:1] == '0))
		else $error("scan started while a token was still in the chain");

	// a commit always lands on the cell that reported the hit
	a_take_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take |-> $onehot(hit_vec))
		else $error("commit without a single hitting cell");

endmodule

[rtl/core/ptst_cell.sv]
// one timer slot of the chain: use and enable bits, period, last-fire time
// and the scan token handed on to the next cell; depends on ptst_pkg
module ptst_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptst_pkg::cell_ctrl_t ctrl,
	input  logic                 tok_in,
	output logic                 tok_out,
	output logic                 hit
);

	logic                          in_use_q;
	logic                          en_q;
	logic                          token_q;
	logic [ptst_pkg::TIME_W-1:0]   period_q;
	logic [ptst_pkg::TIME_W-1:0]   last_q;
	logic [ptst_pkg::TIME_W-1:0]   elapsed;
	logic                          addr_hit;
	logic                          commit;

	assign elapsed  = ctrl.now - last_q;
	assign addr_hit = (IDX < ptst_pkg::SLOT_ADDR_N) &&
		(ctrl.wr_slot == ptst_pkg::SLOT_W'(IDX));
	assign hit = token_q && (ctrl.sub_mode ? !in_use_q :
		(in_use_q && en_q && (elapsed >= period_q)));
	assign commit  = token_q && ctrl.take;
	assign tok_out = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			en_q     <= 1'b0;
			token_q  <= 1'b0;
		end else begin
			if (ctrl.start || ctrl.adv) begin
				token_q <= tok_in && !ctrl.flush;
			end
			if (ctrl.wr_en && addr_hit) begin
				en_q <= ctrl.wr_val;
			end else if (commit && ctrl.sub_mode) begin
				en_q     <= 1'b0;
				in_use_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (ctrl.sub_mode) begin
				period_q <= ctrl.interval;
				last_q   <= '0;
			end else begin
				last_q <= ctrl.now;
			end
		end
	end

endmodule

[rtl/core/ptst_ctrl.sv]
// sequencer: input handshake, time counter, scan walk, pending result
// and output register; drives the cell chain; depends on ptst_pkg
module ptst_ctrl #(
	parameter int SLOTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           s_tuser,
	input  logic [39:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2:0]           m_tuser,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast,
	input  logic                 hit_any,
	output ptst_pkg::cell_ctrl_t ctrl
);

	localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                          state_q;
	logic                            sub_q;
	logic [ptst_pkg::TIME_W-1:0]     time_q;
	logic [ptst_pkg::TIME_W-1:0]     interval_q;
	logic [CW-1:0]                   cnt_q;
	logic [ptst_pkg::FCNT_W-1:0]     fire_cnt_q;
	logic                            have_pend_q;
	ptst_pkg::event_t                pend_ev_q;
	logic [ptst_pkg::ID_W-1:0]       pend_id_q;
	logic                            m_valid_q;
	ptst_pkg::event_t                m_ev_q;
	logic [ptst_pkg::ID_W-1:0]       m_id_q;
	logic                            m_last_q;

	ptst_pkg::kind_t                 kind;
	logic [ptst_pkg::SLOT_W-1:0]     in_slot;
	logic                            accept;
	logic                            scan;
	logic                            out_free;
	logic                            hit_ok;
	logic                            push;
	logic                            step;
	logic                            take;
	logic                            last_cell;
	logic                            done_scan;
	logic                            emit;
	logic                            is_wr;

	assign kind     = ptst_pkg::kind_t'(s_tuser);
	assign in_slot  = s_tdata[4:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_wr    = (kind == ptst_pkg::KIND_ENABLE) || (kind == ptst_pkg::KIND_DISABLE);
	assign scan     = (state_q == ST_SCAN);
	assign out_free = !m_valid_q || m_tready;
	// fires beyond the per-tick result cap are skipped
	assign hit_ok    = hit_any &&
		(sub_q || (fire_cnt_q < ptst_pkg::FCNT_W'(ptst_pkg::MAX_RESULTS)));
	assign push      = scan && !sub_q && hit_ok && have_pend_q;
	assign step      = scan && (!push || out_free);
	assign take      = step && hit_ok;
	assign last_cell = (cnt_q == CW'(SLOTS - 1));
	assign done_scan = step && (last_cell || (sub_q && hit_ok));
	assign emit      = (state_q == ST_EMIT) && out_free;

	always_comb begin
		ctrl          = '0;
		ctrl.start    = accept && !is_wr;
		ctrl.adv      = step;
		ctrl.flush    = done_scan;
		ctrl.take     = take;
		ctrl.sub_mode = sub_q;
		ctrl.wr_en    = accept && is_wr;
		ctrl.wr_val   = (kind == ptst_pkg::KIND_ENABLE);
		ctrl.wr_slot  = in_slot;
		ctrl.now      = time_q;
		ctrl.interval = interval_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			m_valid_q   <= 1'b0;
			have_pend_q <= 1'b0;
			sub_q       <= 1'b0;
			cnt_q       <= '0;
			fire_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sub_q       <= (kind == ptst_pkg::KIND_SUB);
						cnt_q       <= '0;
						fire_cnt_q  <= '0;
						have_pend_q <= 1'b0;
						if (kind == ptst_pkg::KIND_TICK) begin
							time_q <= time_q + 32'd1;
						end
						state_q <= is_wr ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (take) begin
						have_pend_q <= 1'b1;
						if (!sub_q) begin
							fire_cnt_q <= fire_cnt_q + ptst_pkg::FCNT_W'(1);
						end
					end
					if (done_scan) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if ((push && step) || emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			interval_q <= s_tdata[36:5];
			pend_ev_q  <= ptst_pkg::EV_DONE;
			pend_id_q  <= {1'b0, in_slot};
		end
		if (take) begin
			pend_ev_q <= sub_q ? ptst_pkg::EV_SUBSCRIBED : ptst_pkg::EV_FIRED;
			pend_id_q <= ptst_pkg::ID_W'(cnt_q);
		end else if (done_scan && !have_pend_q) begin
			pend_ev_q <= sub_q ? ptst_pkg::EV_FULL : ptst_pkg::EV_NOFIRE;
			pend_id_q <= ptst_pkg::NO_SLOT;
		end
		if (push && step) begin
			m_ev_q   <= pend_ev_q;
			m_id_q   <= pend_id_q;
			m_last_q <= 1'b0;
		end else if (emit) begin
			m_ev_q   <= pend_ev_q;
			m_id_q   <= pend_id_q;
			m_last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_ev_q;
	assign m_tdata  = {2'b00, m_id_q};
	assign m_tlast  = m_last_q;

	// only fire reports can be followed by more items of the same input
	a_nonlast_is_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_last_q) |-> (m_ev_q == ptst_pkg::EV_FIRED))
		else $error("non-final item that is not a fire report");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		scan |-> (fire_cnt_q <= ptst_pkg::FCNT_W'(ptst_pkg::MAX_RESULTS)))
		else $error("fire count beyond cap");

	a_sub_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(scan && sub_q) |-> !have_pend_q)
		else $error("subscribe scan continued after claiming a slot");

endmodule

[verif/testbench.sv]
// self-checking testbench for periodic_tick_subscription_table
// needs ptst_pkg and the rtl top; predicts every result item and checks them in order
module testbench;
	import ptst_pkg::*;

	localparam int TBL_SLOTS   = SLOT_ADDR_N;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		kind_t       kind;
		logic [4:0]  slot;
		logic [31:0] interval;
		bit          wait_idle;   // hold this request back until the table has gone quiet
	} timer_req_t;

	typedef struct {
		event_t     ev;
		logic [5:0] slot_id;
		logic       last;
	} slot_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = KIND_TICK;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [2:0]  m_tuser;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	timer_req_t   timer_requests[$];
	slot_report_t pending_reports[$];

	// shadow copy of the slot table
	logic [31:0] now_ticks;
	bit          slot_taken[TBL_SLOTS];
	bit          slot_on[TBL_SLOTS];
	logic [31:0] slot_period[TBL_SLOTS];
	logic [31:0] slot_fired_at[TBL_SLOTS];

	int err_count, items_sent, reports_seen, fires_seen, full_seen;
	int fires_this_tick, most_fires;
	int cycle_count;
	int burst_left = 4, gap_left = 0;
	int hold_left = 0, mode_left = 0, ready_mode = 0;
	bit hold_done = 0;
	int subs_planned;

	periodic_tick_subscription_table #(.SLOTS(TBL_SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// work out what the table answers to one accepted request
	task automatic table_apply(timer_req_t req);
		logic [31:0] elapsed;
		logic [5:0]  fired[$];
		slot_report_t rep;
		int s;
		case (req.kind)
			KIND_TICK: begin
				now_ticks = now_ticks + 32'd1;
				for (s = 0; s < TBL_SLOTS; s++) begin
					elapsed = now_ticks - slot_fired_at[s];
					if (fired.size() < MAX_RESULTS && slot_taken[s] && slot_on[s] &&
					    elapsed >= slot_period[s]) begin
						slot_fired_at[s] = now_ticks;
						fired.push_back(6'(s));
					end
				end
				if (fired.size() == 0) begin
					rep = '{EV_NOFIRE, NO_SLOT, 1'b1};
					pending_reports.push_back(rep);
				end else begin
					foreach (fired[i]) begin
						rep = '{EV_FIRED, fired[i], i == fired.size() - 1};
						pending_reports.push_back(rep);
					end
				end
			end
			KIND_SUB: begin
				rep = '{EV_FULL, NO_SLOT, 1'b1};
				for (s = 0; s < TBL_SLOTS; s++) begin
					if (!slot_taken[s]) begin
						slot_period[s]   = req.interval;
						slot_fired_at[s] = '0;
						slot_on[s]       = 1'b0;
						slot_taken[s]    = 1'b1;
						rep = '{EV_SUBSCRIBED, 6'(s), 1'b1};
						break;
					end
				end
				pending_reports.push_back(rep);
			end
			default: begin
				if (req.slot < TBL_SLOTS)
					slot_on[req.slot] = (req.kind == KIND_ENABLE);
				rep = '{EV_DONE, {1'b0, req.slot}, 1'b1};
				pending_reports.push_back(rep);
			end
		endcase
	endtask

	task automatic add_req(kind_t kind, logic [4:0] slot, logic [31:0] interval, bit wait_idle);
		timer_req_t req;
		req = '{kind, slot, interval, wait_idle};
		timer_requests.push_back(req);
		if (kind == KIND_SUB)
			subs_planned++;
	endtask

	// mostly short periods so slots fire often, some long and some fully random
	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 12);
		else if (r < 85)
			return $urandom_range(13, 200);
		return $urandom;
	endfunction

	task automatic add_random_reqs(int count, bit wait_first);
		int r, hi;
		logic [4:0] slot;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			// enables and disables mostly aim at slots that are already claimed
			hi = (subs_planned > TBL_SLOTS) ? TBL_SLOTS - 1 : subs_planned;
			if (hi > 0 && $urandom_range(0, 9) < 6)
				slot = 5'($urandom_range(0, hi - 1));
			else
				slot = 5'($urandom_range(0, 31));
			if (r < 45)
				add_req(KIND_TICK, slot, $urandom, wait_first && i == 0);
			else if (r < 57)
				add_req(KIND_SUB, slot, pick_period(), wait_first && i == 0);
			else if (r < 85)
				add_req(KIND_ENABLE, slot, $urandom, wait_first && i == 0);
			else
				add_req(KIND_DISABLE, slot, $urandom, wait_first && i == 0);
		end
	endtask

	// sender: bursts of requests separated by random gaps
	always @(posedge clk) begin : req_driver
		timer_req_t req;
		if (s_tvalid && s_tready) begin
			req = timer_requests.pop_front();
			table_apply(req);
			items_sent++;
		end
		if (!(s_tvalid && !s_tready)) begin
			if (!arst_n || timer_requests.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (timer_requests[0].wait_idle && pending_reports.size() != 0) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tuser  <= timer_requests[0].kind;
				s_tdata  <= {3'b000, timer_requests[0].interval, timer_requests[0].slot};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
					                                         : $urandom_range(1, 8);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end
		end
	end

	// receiver: stall pattern changes every so often, plus one long hold-off
	always @(posedge clk) begin : report_sink
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && reports_seen >= 120) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(50, 250);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= ($urandom_range(0, 4) == 0);
				default: m_tready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	// compare each delivered result item with the oldest prediction
	always @(posedge clk) begin : report_check
		slot_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			reports_seen++;
			if (m_tuser == EV_FIRED) begin
				fires_seen++;
				fires_this_tick++;
				if (fires_this_tick > most_fires)
					most_fires = fires_this_tick;
			end
			if (m_tuser == EV_FULL)
				full_seen++;
			if (m_tlast)
				fires_this_tick = 0;
			if (pending_reports.size() == 0) begin
				err_count++;
				$display("%0t: unexpected item: event_res %0d slot_id %0d last %0b",
				         $time, m_tuser, m_tdata[5:0], m_tlast);
			end else begin
				want = pending_reports.pop_front();
				if (m_tuser !== want.ev) begin
					err_count++;
					$display("%0t: event_res expected %0d actual %0d", $time, want.ev, m_tuser);
				end
				if (m_tdata[5:0] !== want.slot_id) begin
					err_count++;
					$display("%0t: slot_id expected %0d actual %0d",
					         $time, want.slot_id, m_tdata[5:0]);
				end
				if (m_tlast !== want.last) begin
					err_count++;
					$display("%0t: last expected %0b actual %0b", $time, want.last, m_tlast);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still expected",
		         cycle_count, pending_reports.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin : run_ctrl
		now_ticks = '0;
		foreach (slot_taken[s]) begin
			slot_taken[s] = 1'b0;
			slot_on[s]    = 1'b0;
		end

		// directed part
		add_req(KIND_TICK,    5'd0,  32'hFFFF_FFFF, 0);  // nothing claimed yet
		add_req(KIND_ENABLE,  5'd5,  32'h0,         0);  // enable of a free slot
		add_req(KIND_DISABLE, 5'd31, 32'h5A5A_A5A5, 0);
		add_req(KIND_SUB,     5'd31, 32'd0,         0);  // zero period
		add_req(KIND_SUB,     5'd0,  32'hFFFF_FFFF, 0);  // longest period
		add_req(KIND_SUB,     5'd17, 32'd3,         0);
		add_req(KIND_SUB,     5'd9,  32'd1,         0);
		add_req(KIND_ENABLE,  5'd0,  32'h0,         0);
		add_req(KIND_ENABLE,  5'd1,  32'h0,         0);
		add_req(KIND_ENABLE,  5'd2,  32'h0,         0);
		add_req(KIND_ENABLE,  5'd3,  32'h0,         0);
		add_req(KIND_TICK,    5'd31, 32'h0,         0);
		add_req(KIND_TICK,    5'd0,  32'h0,         0);
		add_req(KIND_TICK,    5'd0,  32'h0,         0);
		add_req(KIND_SUB,     5'd0,  32'd2,         0);
		add_req(KIND_SUB,     5'd0,  32'd0,         0);  // lands on the pre-enabled slot, clears it
		add_req(KIND_TICK,    5'd0,  32'h0,         0);
		add_req(KIND_DISABLE, 5'd0,  32'h0,         0);
		add_req(KIND_ENABLE,  5'd5,  32'h0,         0);
		add_req(KIND_ENABLE,  5'd4,  32'h0,         0);
		add_req(KIND_TICK,    5'd0,  32'h0,         0);
		add_req(KIND_TICK,    5'd0,  32'h0,         0);

		// random part, split by one pause that lets the table drain
		add_random_reqs(180, 1);
		add_random_reqs(180, 1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (timer_requests.size() != 0 || pending_reports.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (TBL_SLOTS + 20) @(posedge clk);

		$display("covered %0d requests and %0d result items: %0d slot fires, %0d table-full",
		         items_sent, reports_seen, fires_seen, full_seen);
		$display("most slots fired on one tick: %0d, final tick count %0d",
		         most_fires, now_ticks);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", err_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/ptst_pkg.sv
rtl/core/ptst_cell.sv
rtl/core/ptst_ctrl.sv
rtl/core/periodic_tick_subscription_table.sv
verif/testbench.sv
